@@ hw/rtl/srip_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srip_pkg
// Shared types, codes and sizes for the swap-remove ID pool.
// ----------------------------------------------------------------------------
package srip_pkg;

   localparam int MAX_IDS_DEFAULT = 256;

   localparam int ID_W          = 8;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;
   localparam int LIVE_W        = 9;
   localparam int LIMIT_W       = 9;
   localparam int REQ_TDATA_W   = 24;
   localparam int RSP_TDATA_W   = 24;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

   localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE_ID = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_AT = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ACTIVE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX  = 2'd3;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ_ALLOC,
      S_READ_POS,
      S_SCAN,
      S_READ_LAST,
      S_WRITE_LAST,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic [ID_W-1:0] entity_id;
      logic [ID_W-1:0] active_index;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     result_id;
      logic [STATUS_W-1:0] status;
      logic [LIVE_W-1:0]   live_count;
   } rsp_type;

   typedef struct packed {
      logic ready;
      logic done;
   } ctrl_status_type;

endpackage

@@ hw/rtl/srip_pool_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srip_pool_mem
// ID pool storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srip_pool_mem
   import srip_pkg::*;
#(
   parameter int MAX_IDS = MAX_IDS_DEFAULT,
   parameter int AW      = $clog2(MAX_IDS)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [ID_W-1:0] wr_data,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output logic [ID_W-1:0] rd_data
);

   logic [ID_W-1:0] mem [MAX_IDS];
   logic [ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/srip_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srip_ctrl
// Sequencer: clear pass, allocate, scan for an ID, swap with last and pop.
// ----------------------------------------------------------------------------
module srip_ctrl
   import srip_pkg::*;
#(
   parameter int MAX_IDS = MAX_IDS_DEFAULT,
   parameter int AW      = $clog2(MAX_IDS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [LIMIT_W-1:0]  limit,
   input  req_type             req,
   input  logic                req_take,
   input  logic                result_take,
   output ctrl_status_type     stat,
   output rsp_type             result,
   output logic                mem_wr_en,
   output logic [AW-1:0]       mem_wr_addr,
   output logic [ID_W-1:0]     mem_wr_data,
   output logic                mem_rd_en,
   output logic [AW-1:0]       mem_rd_addr,
   input  logic [ID_W-1:0]     mem_rd_data
);

   localparam int CW   = $clog2(MAX_IDS + 1);
   localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_IDS);
   localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_IDS - 1);

   ctrl_state_type     state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [ID_W-1:0]    want_ff, want_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      scan_ff, scan_in;
   logic [ID_W-1:0]    gone_ff, gone_in;
   rsp_type            res_ff, res_in;

   logic            can_alloc;
   logic            idx_ok;
   logic            count_zero;
   logic [AW-1:0]   last_addr;
   logic [AW-1:0]   scan_next;
   logic            scan_end;
   logic            match;
   logic [CW-1:0]   count_inc;
   logic [CW-1:0]   count_dec;

   assign count_inc  = count_ff + CW'(1);
   assign count_dec  = count_ff - CW'(1);
   assign can_alloc  = (CMPW'(count_ff) < CMPW'(limit)) && (count_ff != COUNT_MAX);
   assign idx_ok     = CMPW'(req.active_index) < CMPW'(count_ff);
   assign count_zero = count_ff == CW'(0);
   assign last_addr  = AW'(count_dec);
   assign scan_next  = scan_ff + AW'(1);
   assign scan_end   = (CW'(scan_ff) + CW'(1)) == count_ff;
   assign match      = mem_rd_data == want_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (scan_ff == ADDR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               unique case (req.operation)
                  OP_ALLOC:     state_in = can_alloc ? S_READ_ALLOC : S_DONE;
                  OP_REMOVE_ID: state_in = count_zero ? S_DONE : S_SCAN;
                  OP_REMOVE_AT: state_in = idx_ok ? S_READ_POS : S_DONE;
                  default:      state_in = S_DONE;
               endcase
            end
         end
         S_READ_ALLOC: state_in = S_DONE;
         S_READ_POS:   state_in = S_READ_LAST;
         S_SCAN: begin
            if (match) begin
               state_in = S_READ_LAST;
            end else if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_READ_LAST:  state_in = S_WRITE_LAST;
         S_WRITE_LAST: state_in = S_DONE;
         S_DONE: begin
            if (result_take) begin
               state_in = S_IDLE;
            end
         end
         default:      state_in = S_CLEAR;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      count_in    = count_ff;
      want_in     = want_ff;
      pos_in      = pos_ff;
      scan_in     = scan_ff;
      gone_in     = gone_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = pos_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = scan_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = scan_ff;
            mem_wr_data = ID_W'(scan_ff);
            scan_in     = (scan_ff == ADDR_LAST) ? AW'(0) : scan_next;
         end
         S_IDLE: begin
            if (req_take) begin
               want_in = req.entity_id;
               pos_in  = AW'(req.active_index);
               scan_in = AW'(0);
               res_in  = '{result_id: '0, status: STATUS_OK,
                           live_count: LIVE_W'(count_ff)};
               unique case (req.operation)
                  OP_ALLOC: begin
                     if (can_alloc) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(count_ff);
                     end else begin
                        res_in.status = STATUS_FULL;
                     end
                  end
                  OP_REMOVE_ID: begin
                     if (count_zero) begin
                        res_in.status = STATUS_NOT_ACTIVE;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(0);
                     end
                  end
                  OP_REMOVE_AT: begin
                     if (idx_ok) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(req.active_index);
                     end else begin
                        res_in.status = STATUS_BAD_INDEX;
                     end
                  end
                  default: begin
                     res_in.status = STATUS_OK;
                  end
               endcase
            end
         end
         S_READ_ALLOC: begin
            count_in = count_inc;
            res_in   = '{result_id: mem_rd_data, status: STATUS_OK,
                         live_count: LIVE_W'(count_inc)};
         end
         S_READ_POS: begin
            gone_in     = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = last_addr;
         end
         S_SCAN: begin
            if (match) begin
               pos_in      = scan_ff;
               gone_in     = want_ff;
               mem_rd_en   = 1'b1;
               mem_rd_addr = last_addr;
            end else if (scan_end) begin
               res_in = '{result_id: '0, status: STATUS_NOT_ACTIVE,
                          live_count: LIVE_W'(count_ff)};
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = scan_next;
               scan_in     = scan_next;
            end
         end
         S_READ_LAST: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_ff;
            mem_wr_data = mem_rd_data;
         end
         S_WRITE_LAST: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = last_addr;
            mem_wr_data = gone_ff;
            count_in    = count_dec;
            res_in      = '{result_id: gone_ff, status: STATUS_OK,
                            live_count: LIVE_W'(count_dec)};
         end
         S_DONE: begin
            res_in = res_ff;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      pos_ff  <= pos_in;
      gone_ff <= gone_in;
      res_ff  <= res_in;
   end

   assign stat.ready = state_ff == S_IDLE;
   assign stat.done  = state_ff == S_DONE;
   assign result     = res_ff;

endmodule

@@ hw/rtl/swap_remove_id_pool_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_remove_id_pool_top
// Dense ID allocator: live IDs packed at the front of one pool memory,
// removal swaps the chosen entry with the last live entry.
// ----------------------------------------------------------------------------
//  channel | direction | ports                              | contents
//  req     | in        | req_tvalid, req_tready, req_tdata  | operation, id, index
//  rsp     | out       | rsp_tvalid, rsp_tready, rsp_tdata  | id, status, live count
//  csr     | in        | csr_wr_en, csr_wr_data             | limit
//
//  Remove by ID scans the live entries from the front, one entry per cycle,
//  until it finds a match or has checked the last live entry.
//  After reset a clearing pass writes entry i with i for every entry;
//  req_tready stays low meanwhile, csr writes are taken as ever.
//  The output register lets the next item enter while a result waits.
// ----------------------------------------------------------------------------
module swap_remove_id_pool_top
   import srip_pkg::*;
#(
   parameter int MAX_IDS = MAX_IDS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [1:0] operation, [9:2] entity_id, [17:10] active_index, [23:18] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] result_id, [9:8] status, [18:10] live_count, [23:19] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [LIMIT_W-1:0]     csr_wr_data
);

   localparam int AW = $clog2(MAX_IDS);

   logic [LIMIT_W-1:0] limit_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   req_type         req;
   rsp_type         result;
   ctrl_status_type ctrl_stat;
   logic            req_take;
   logic            load;

   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   logic [ID_W-1:0] mem_wr_data;
   logic            mem_rd_en;
   logic [AW-1:0]   mem_rd_addr;
   logic [ID_W-1:0] mem_rd_data;

   assign req.operation    = req_tdata[1:0];
   assign req.entity_id    = req_tdata[9:2];
   assign req.active_index = req_tdata[17:10];

   assign req_tready = ctrl_stat.ready;
   assign req_take   = req_tvalid && req_tready;
   assign load       = ctrl_stat.done && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.live_count, rsp_data_ff.status,
                        rsp_data_ff.result_id};

   srip_ctrl #(
      .MAX_IDS (MAX_IDS),
      .AW      (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .limit       (limit_ff),
      .req         (req),
      .req_take    (req_take),
      .result_take (load),
      .stat        (ctrl_stat),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   srip_pool_mem #(
      .MAX_IDS (MAX_IDS),
      .AW      (AW)
   ) u_pool_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("sequencer took a second item while busy");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      ctrl_stat.done && !load |=> ctrl_stat.done)
      else $error("finished result dropped before transfer");

   a_no_ready_and_done: assert property (@(posedge clock) disable iff (reset)
      !(ctrl_stat.ready && ctrl_stat.done))
      else $error("sequencer idle and done at once");

endmodule

@@ tb/swap_remove_id_pool_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_remove_id_pool_top_tb
// Self-checking bench for the swap-remove ID pool. A scoreboard keeps its own
// pool array, live count and limit, computes the response for every accepted
// request and matches responses in order. Stimulus is a directed opening,
// then random phases under several limits (0, 1, mid, 256, 511), mostly
// valid removes of live IDs and positions mixed with misses and noise.
// Both channels idle at random except in one phase. One long response stall backs up the block.
// ----------------------------------------------------------------------------
module swap_remove_id_pool_top_tb;
   import srip_pkg::*;

   localparam int                POOL_DEPTH = MAX_IDS_DEFAULT;
   localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
   localparam int                HOLD_CYCLES = 400;

   class id_pool_scoreboard;
      logic [ID_W-1:0]    pool [POOL_DEPTH];
      logic [LIVE_W-1:0]  live;
      logic [LIMIT_W-1:0] limit;
      rsp_type            pending_rsp [$];
      int                 errors;
      int                 checked;
      int                 op_seen [4];
      int                 status_seen [4];
      int                 peak_live;

      function new();
         for (int i = 0; i < POOL_DEPTH; i++) pool[i] = ID_W'(i);
         live = '0;
         limit = LIMIT_RESET;
         errors = 0;
         checked = 0;
         peak_live = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit = value;
      endfunction

      function logic [ID_W-1:0] swap_out(int pos);
         logic [ID_W-1:0] gone;
         int last;
         last = int'(live) - 1;
         gone = pool[pos];
         pool[pos] = pool[last];
         pool[last] = gone;
         live = LIVE_W'(last);
         return gone;
      endfunction

      function void note_request(req_type req);
         rsp_type rsp;
         int      cap;
         bit      found;
         cap = (int'(limit) < POOL_DEPTH) ? int'(limit) : POOL_DEPTH;
         rsp.result_id = '0;
         rsp.status = STATUS_OK;
         found = 0;
         case (req.operation)
            OP_ALLOC: begin
               if (int'(live) < cap) begin
                  rsp.result_id = pool[live];
                  live = live + 1'b1;
               end else begin
                  rsp.status = STATUS_FULL;
               end
            end
            OP_REMOVE_ID: begin
               for (int i = 0; i < int'(live) && !found; i++) begin
                  if (pool[i] == req.entity_id) begin
                     rsp.result_id = swap_out(i);
                     found = 1;
                  end
               end
               if (!found) rsp.status = STATUS_NOT_ACTIVE;
            end
            OP_REMOVE_AT: begin
               if (int'(req.active_index) < int'(live))
                  rsp.result_id = swap_out(int'(req.active_index));
               else
                  rsp.status = STATUS_BAD_INDEX;
            end
            default: ;
         endcase
         rsp.live_count = live;
         if (int'(live) > peak_live) peak_live = int'(live);
         op_seen[req.operation]++;
         status_seen[rsp.status]++;
         pending_rsp.push_back(rsp);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] data);
         rsp_type got;
         rsp_type want;
         got.result_id  = data[7:0];
         got.status     = data[9:8];
         got.live_count = data[18:10];
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected item, got id %0d status %0d live %0d",
                     $time, got.result_id, got.status, got.live_count);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         checked++;
         if (got.result_id !== want.result_id) begin
            $display("%0t: result_id mismatch, expected %0d, actual %0d",
                     $time, want.result_id, got.result_id);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
         end
         if (got.live_count !== want.live_count) begin
            $display("%0t: live_count mismatch, expected %0d, actual %0d",
                     $time, want.live_count, got.live_count);
            errors++;
         end
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]     csr_wr_data = '0;

   id_pool_scoreboard sb = new();
   bit                idle_enable = 1'b1;
   bit                stall_request = 1'b0;
   int                stall_left = 0;
   int                limits_used = 0;

   swap_remove_id_pool_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // response side: check, then pick ready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if (stall_request) begin
         stall_left = HOLD_CYCLES;
         stall_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_enable) begin
         rsp_tready <= ($urandom_range(0, 99) >= 25);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                            logic [ID_W-1:0] idx);
      req_type req;
      req.operation = op;
      req.entity_id = id;
      req.active_index = idx;
      req_tdata  <= {6'd0, idx, id, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(req);
      while (idle_enable && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_and_park();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_limit(value);
      limits_used++;
   endtask

   // mostly well-formed removes of live IDs and positions, some misses and noise
   task automatic send_random(int alloc_weight);
      int              pick;
      int              n;
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] idx;
      pick = $urandom_range(0, 99);
      n = int'(sb.live);
      id = ID_W'($urandom_range(0, 255));
      idx = ID_W'($urandom_range(0, 255));
      if (pick < 3) begin
         op = OP_UNUSED;
      end else if (pick < alloc_weight) begin
         op = OP_ALLOC;
      end else if (pick < alloc_weight + (100 - alloc_weight) / 2) begin
         op = OP_REMOVE_ID;
         if (n > 0 && $urandom_range(0, 99) < 75) id = sb.pool[$urandom_range(0, n - 1)];
      end else begin
         op = OP_REMOVE_AT;
         if (n > 0 && $urandom_range(0, 99) < 75) idx = ID_W'($urandom_range(0, n - 1));
      end
      send_item(op, id, idx);
   endtask

   task automatic random_phase(logic [LIMIT_W-1:0] lim, int items, int alloc_weight,
                               bit idle, int hold_at);
      drain_and_park();
      write_limit(lim);
      idle_enable = idle;
      for (int i = 0; i < items; i++) begin
         if (i == hold_at) stall_request = 1'b1;
         send_random(alloc_weight);
      end
   endtask

   initial begin
      int guard;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_limit(9'd4);

      // empty pool, unused code, fill past a small limit
      send_item(OP_REMOVE_AT, 8'd0, 8'd0);
      send_item(OP_REMOVE_ID, 8'd0, 8'd255);
      send_item(OP_UNUSED, 8'd255, 8'd255);
      send_item(OP_ALLOC, 8'd255, 8'd255);
      send_item(OP_ALLOC, 8'd0, 8'd0);
      send_item(OP_ALLOC, 8'd170, 8'd85);
      send_item(OP_ALLOC, 8'd85, 8'd170);
      send_item(OP_ALLOC, 8'd0, 8'd0);
      // removals: hit, miss on a freed ID, out of range, last entry
      send_item(OP_REMOVE_ID, 8'd2, 8'd0);
      send_item(OP_REMOVE_ID, 8'd2, 8'd0);
      send_item(OP_REMOVE_ID, 8'd255, 8'd0);
      send_item(OP_REMOVE_AT, 8'd0, 8'd255);
      send_item(OP_REMOVE_AT, 8'd0, 8'd3);
      send_item(OP_REMOVE_AT, 8'd0, 8'd2);
      send_item(OP_ALLOC, 8'd0, 8'd0);
      send_item(OP_REMOVE_AT, 8'd0, 8'd0);

      // limit dropped to zero below the live count
      drain_and_park();
      write_limit(9'd0);
      send_item(OP_ALLOC, 8'd0, 8'd0);
      send_item(OP_REMOVE_AT, 8'd0, 8'd1);
      send_item(OP_REMOVE_ID, sb.pool[0], 8'd0);
      send_item(OP_ALLOC, 8'd0, 8'd0);

      random_phase(9'd511, 340, 92, 1'b1, 60);
      random_phase(9'd256, 120, 40, 1'b0, -1);
      random_phase(9'd1, 60, 50, 1'b1, -1);
      random_phase(LIMIT_W'($urandom_range(2, 255)), 100, 60, 1'b1, -1);
      random_phase(9'd0, 40, 40, 1'b1, -1);
      random_phase(9'd256, 60, 55, 1'b1, -1);

      req_tvalid <= 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (300) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, sb.pending());
         sb.errors++;
      end

      $display("ran %0d items over %0d limit settings: alloc %0d, remove-id %0d,",
               sb.checked, limits_used, sb.op_seen[OP_ALLOC], sb.op_seen[OP_REMOVE_ID]);
      $display("remove-at %0d, unused %0d; statuses ok %0d, full %0d, not-active %0d,",
               sb.op_seen[OP_REMOVE_AT], sb.op_seen[OP_UNUSED],
               sb.status_seen[STATUS_OK], sb.status_seen[STATUS_FULL],
               sb.status_seen[STATUS_NOT_ACTIVE]);
      $display("bad-index %0d; peak live %0d",
               sb.status_seen[STATUS_BAD_INDEX], sb.peak_live);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("%0t: timeout", $time);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
